// ===== design/ppbc_pkg.sv =====
// Shared types, sizes and helpers for the perceptron predictor with block commit.
// Used by ppbc_weight_bank and perceptron_predictor_block_commit_unit.
// No dependencies.
`default_nettype none

package ppbc_pkg;

   // predictor geometry
   localparam int NUM_WEIGHTS = 16;
   localparam int WEIGHT_BITS = 8;

   // fixed field widths
   localparam int BITS_W    = 16;
   localparam int GSUM_W    = 14;
   localparam int SUM_OUT_W = 14;
   localparam int THR_W     = 5;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(10);

   // adder tree sizing
   localparam int NUM_TERMS  = 2 * NUM_WEIGHTS;
   localparam int GROUP_SIZE = 8;
   localparam int NUM_GROUPS = (NUM_TERMS + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PART_W     = WEIGHT_BITS + 1 + $clog2(GROUP_SIZE);
   localparam int SUM_RAW_W  = WEIGHT_BITS + $clog2(NUM_TERMS + 1) + 1;
   localparam int SUM_W      = (SUM_RAW_W > SUM_OUT_W + 1) ? SUM_RAW_W : SUM_OUT_W + 1;

   typedef enum logic [1:0] {
      OP_PREDICT = 2'd0,
      OP_TRAIN   = 2'd1,
      OP_COMMIT  = 2'd2,
      OP_CLEAR   = 2'd3
   } opcode_type;

   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef weight_type weight_arr_type [NUM_WEIGHTS];

   // update command from the pipeline to the weight bank
   typedef struct packed {
      logic              apply;
      opcode_type        opcode;
      logic [BITS_W-1:0] history_bits;
      logic [BITS_W-1:0] inblock_bits;
      logic              outcome;
      logic              mispredicted;
   } wb_cmd_type;

   // input bit seen by weight i; weights past the input width see a zero
   function automatic logic input_bit(input logic [BITS_W-1:0] bits, input int idx);
      logic b;
      b = 1'b0;
      if (idx < BITS_W) begin
         b = bits[idx];
      end
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== design/perceptron_predictor_block_commit_unit.sv =====
// Top level of the perceptron predictor with block commit: handshake, pipeline, adder tree.
// Depends on ppbc_pkg and ppbc_weight_bank.
//
//  channel  | ports                               | role
//  ---------+-------------------------------------+----------------------------------
//  req      | req_tvalid/tready/tdata/tuser       | predict, train, commit, clear item
//  rsp      | rsp_tvalid/tready/tdata             | one result item per request item
//  csr      | csr_wr_en, csr_wr_data              | confidence threshold write
//
// One item per cycle sustained while rsp_tready stays high; each result passes the
// input register, partial-sum register and result register in order.
// Weight updates land as an item leaves the input register, so the next item
// already sees them. Reset zeroes all weights.
// Each stage advances when the stage after it is empty or moving, so bubbles
// close up while rsp_tready is low.
`default_nettype none

module perceptron_predictor_block_commit_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // history_bits[15:0], inblock_bits[31:16], outcome[32], given_sum[46:33]
   input  wire logic [47:0]                   req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]                    req_tuser,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // sum_out[13:0], taken[14], confident[15], mispredicted[16]
   output logic [23:0]                        rsp_tdata,
   input  wire logic                          csr_wr_en,
   input  wire logic [ppbc_pkg::THR_W-1:0]    csr_wr_data
);
   import ppbc_pkg::*;

   localparam logic signed [SUM_W-1:0] CLIP_MAX = SUM_W'(2**(SUM_OUT_W-1) - 1);
   localparam logic signed [SUM_W-1:0] CLIP_MIN = SUM_W'(-(2**(SUM_OUT_W-1)));

   // threshold register
   logic [THR_W-1:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // stage enables
   logic s0_valid_ff, s1_valid_ff, rsp_valid_ff;
   logic en0, en1, en2;
   assign en2 = !rsp_valid_ff || rsp_tready;
   assign en1 = !s1_valid_ff || en2;
   assign en0 = !s0_valid_ff || en1;
   assign req_tready = en0;

   // input register
   opcode_type        s0_op_ff;
   logic [BITS_W-1:0] s0_hist_ff, s0_blk_ff;
   logic              s0_outcome_ff, s0_gneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en0) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en0 && req_tvalid) begin
         s0_op_ff      <= opcode_type'(req_tuser);
         s0_hist_ff    <= req_tdata[15:0];
         s0_blk_ff     <= req_tdata[31:16];
         s0_outcome_ff <= req_tdata[32];
         s0_gneg_ff    <= req_tdata[33 + GSUM_W - 1];
      end
   end

   // misprediction: a non-negative sum means taken
   logic s0_miss;
   assign s0_miss = (s0_op_ff == OP_TRAIN) && (s0_gneg_ff == s0_outcome_ff);

   // weight bank, updated as the item moves on
   wb_cmd_type     wb_cmd;
   weight_arr_type hist_w, blk_w;
   weight_type     bias_w;

   always_comb begin
      wb_cmd.apply        = s0_valid_ff && en1;
      wb_cmd.opcode       = s0_op_ff;
      wb_cmd.history_bits = s0_hist_ff;
      wb_cmd.inblock_bits = s0_blk_ff;
      wb_cmd.outcome      = s0_outcome_ff;
      wb_cmd.mispredicted = s0_miss;
   end

   ppbc_weight_bank u_weight_bank (
      .clock          (clock),
      .reset          (reset),
      .cmd            (wb_cmd),
      .history_weight (hist_w),
      .inblock_weight (blk_w),
      .bias_weight    (bias_w)
   );

   // signed terms and group partial sums
   logic signed [PART_W-1:0] terms [NUM_TERMS];
   logic signed [PART_W-1:0] parts [NUM_GROUPS];

   always_comb begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
         terms[i] = input_bit(s0_hist_ff, i) ? PART_W'(hist_w[i]) : -PART_W'(hist_w[i]);
         terms[NUM_WEIGHTS + i] =
            input_bit(s0_blk_ff, i) ? PART_W'(blk_w[i]) : -PART_W'(blk_w[i]);
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         parts[g] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (g * GROUP_SIZE + j < NUM_TERMS) begin
               parts[g] = parts[g] + terms[g * GROUP_SIZE + j];
            end
         end
      end
   end

   // partial-sum register
   logic                     s1_predict_ff, s1_miss_ff;
   logic signed [PART_W-1:0] s1_parts_ff [NUM_GROUPS];
   weight_type               s1_bias_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && s0_valid_ff) begin
         s1_predict_ff <= (s0_op_ff == OP_PREDICT);
         s1_miss_ff    <= s0_miss;
         s1_parts_ff   <= parts;
         s1_bias_ff    <= bias_w;
      end
   end

   // final sum, clip and confidence
   logic signed [SUM_W-1:0] total;
   logic signed [SUM_W-1:0] clipped;
   logic [SUM_W-1:0]        mag;
   logic                    conf;

   always_comb begin
      total = SUM_W'(s1_bias_ff);
      for (int g = 0; g < NUM_GROUPS; g++) begin
         total = total + SUM_W'(s1_parts_ff[g]);
      end
      clipped = total;
      if (total > CLIP_MAX) begin
         clipped = CLIP_MAX;
      end else if (total < CLIP_MIN) begin
         clipped = CLIP_MIN;
      end
      mag  = total[SUM_W-1] ? (~total + SUM_W'(1)) : total;
      conf = (mag >= SUM_W'(thr_ff));
   end

   // result register
   logic [SUM_OUT_W-1:0] rsp_sum_ff;
   logic                 rsp_taken_ff, rsp_conf_ff, rsp_miss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en2) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid_ff) begin
         rsp_sum_ff   <= s1_predict_ff ? clipped[SUM_OUT_W-1:0] : '0;
         rsp_taken_ff <= s1_predict_ff && !total[SUM_W-1];
         rsp_conf_ff  <= s1_predict_ff && conf;
         rsp_miss_ff  <= s1_miss_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_miss_ff, rsp_conf_ff, rsp_taken_ff, rsp_sum_ff};

endmodule

`default_nettype wire

// ===== design/ppbc_weight_bank.sv =====
// Live and pending perceptron weights with train, commit and clear updates.
// Depends on ppbc_pkg.
`default_nettype none

module ppbc_weight_bank (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ppbc_pkg::wb_cmd_type    cmd,
   output ppbc_pkg::weight_arr_type     history_weight,
   output ppbc_pkg::weight_arr_type     inblock_weight,
   output ppbc_pkg::weight_type         bias_weight
);
   import ppbc_pkg::*;

   localparam weight_type W_PLUS  = weight_type'(1);
   localparam weight_type W_MINUS = '1;
   localparam weight_type W_MAX   = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam weight_type W_MIN   = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   // saturating add at weight width
   function automatic weight_type sat_add(input weight_type a, input weight_type b);
      logic signed [WEIGHT_BITS:0] s;
      weight_type r;
      s = {a[WEIGHT_BITS-1], a} + {b[WEIGHT_BITS-1], b};
      r = s[WEIGHT_BITS-1:0];
      if (s[WEIGHT_BITS] != s[WEIGHT_BITS-1]) begin
         r = s[WEIGHT_BITS] ? W_MIN : W_MAX;
      end
      return r;
   endfunction

   weight_arr_type hist_w_ff, hist_w_in;
   weight_arr_type blk_w_ff, blk_w_in;
   weight_type     bias_ff, bias_in;
   weight_arr_type pend_hist_ff, pend_hist_in;
   weight_arr_type pend_blk_ff, pend_blk_in;
   weight_type     pend_bias_ff, pend_bias_in;

   // next weight values
   always_comb begin
      hist_w_in    = hist_w_ff;
      blk_w_in     = blk_w_ff;
      bias_in      = bias_ff;
      pend_hist_in = pend_hist_ff;
      pend_blk_in  = pend_blk_ff;
      pend_bias_in = pend_bias_ff;
      if (cmd.apply) begin
         unique case (cmd.opcode)
            OP_PREDICT: begin
            end
            OP_TRAIN: begin
               if (cmd.mispredicted) begin
                  pend_bias_in = sat_add(pend_bias_ff, cmd.outcome ? W_PLUS : W_MINUS);
                  for (int i = 0; i < NUM_WEIGHTS; i++) begin
                     pend_hist_in[i] = sat_add(pend_hist_ff[i],
                        (cmd.outcome == input_bit(cmd.history_bits, i)) ? W_PLUS : W_MINUS);
                     pend_blk_in[i] = sat_add(pend_blk_ff[i],
                        (cmd.outcome == input_bit(cmd.inblock_bits, i)) ? W_PLUS : W_MINUS);
                  end
               end
            end
            OP_COMMIT: begin
               for (int i = 0; i < NUM_WEIGHTS; i++) begin
                  hist_w_in[i]    = sat_add(hist_w_ff[i], pend_hist_ff[i]);
                  blk_w_in[i]     = sat_add(blk_w_ff[i], pend_blk_ff[i]);
                  pend_hist_in[i] = '0;
                  pend_blk_in[i]  = '0;
               end
               bias_in      = sat_add(bias_ff, pend_bias_ff);
               pend_bias_in = '0;
            end
            OP_CLEAR: begin
               for (int i = 0; i < NUM_WEIGHTS; i++) begin
                  pend_hist_in[i] = '0;
                  pend_blk_in[i]  = '0;
               end
               pend_bias_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   // weight storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_WEIGHTS; i++) begin
            hist_w_ff[i]    <= '0;
            blk_w_ff[i]     <= '0;
            pend_hist_ff[i] <= '0;
            pend_blk_ff[i]  <= '0;
         end
         bias_ff      <= '0;
         pend_bias_ff <= '0;
      end else begin
         hist_w_ff    <= hist_w_in;
         blk_w_ff     <= blk_w_in;
         bias_ff      <= bias_in;
         pend_hist_ff <= pend_hist_in;
         pend_blk_ff  <= pend_blk_in;
         pend_bias_ff <= pend_bias_in;
      end
   end

   assign history_weight = hist_w_ff;
   assign inblock_weight = blk_w_ff;
   assign bias_weight    = bias_ff;

endmodule

`default_nettype wire
